// ===== rtl/plid_pkg.sv =====
package plid_pkg;

  localparam int unsigned OpcodeWidth   = 2;
  localparam int unsigned PositionWidth = 5;
  localparam int unsigned ValueWidth    = 32;
  localparam int unsigned StatusWidth   = 2;

  localparam logic [OpcodeWidth-1:0] OPC_INSERT = 2'd0;
  localparam logic [OpcodeWidth-1:0] OPC_DELETE = 2'd1;
  localparam logic [OpcodeWidth-1:0] OPC_LIST   = 2'd2;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_LIST = 1'b1
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic exec;        // run the accepted operation
    logic list_start;  // reset the listing index
    logic list_step;   // emit head cell and rotate
  } plid_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
    logic count_zero;  // list holds no element
    logic list_final;  // listing index sits on the last element
  } plid_sts_t;

endpackage

// ===== rtl/positional_list_insert_delete_unit.sv =====
// an insert or delete result is valid the cycle after its input transfer; the first
// listed element is registered from the head cell on the first step of the listing state
// one insert or delete per cycle; listing a nonempty list holds input off until every
// element has been shifted out of the rotating cell chain
// input is also held off while the output register is full and not taken
// reset (rst_ni low, asynchronous) empties the list and drops any pending result
module positional_list_insert_delete_unit import plid_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // opcode[1:0], position[6:2], value[38:7], pad[39]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // value_res[31:0]
  output logic [1:0]  m_axis_tuser,   // status[1:0]
  output logic        m_axis_tlast    // last result of the operation
);

  plid_cmd_t cmd;
  plid_sts_t sts;

  // field unpacking of the input transfer
  logic [OpcodeWidth-1:0]   opcode;
  logic [PositionWidth-1:0] position;
  logic [ValueWidth-1:0]    value;

  assign opcode   = s_axis_tdata[1:0];
  assign position = s_axis_tdata[6:2];
  assign value    = s_axis_tdata[38:7];

  // sequencer: decides when an operation runs and steps listings
  plid_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .opcode_i  (opcode),
    .sts_i     (sts),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  // cell chain, element count and output register
  plid_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .opcode_i    (opcode),
    .position_i  (position),
    .value_i     (value),
    .m_ready_i   (m_axis_tready),
    .m_valid_o   (m_axis_tvalid),
    .status_o    (m_axis_tuser),
    .value_res_o (m_axis_tdata),
    .last_o      (m_axis_tlast)
  );

endmodule

// ===== rtl/plid_ctrl.sv =====
module plid_ctrl import plid_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  input  logic [OpcodeWidth-1:0] opcode_i,
  input  plid_sts_t              sts_i,
  output logic                   s_ready_o,
  output plid_cmd_t              cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        accept;

  assign s_ready_o = (state_q == CS_IDLE) && sts_i.out_free;
  assign accept    = s_valid_i && s_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (accept && (opcode_i == OPC_LIST) && !sts_i.count_zero) begin
          state_d = CS_LIST;
        end
      end
      CS_LIST: begin
        if (sts_i.out_free && sts_i.list_final) begin
          state_d = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      CS_IDLE: begin
        if (accept) begin
          if ((opcode_i == OPC_LIST) && !sts_i.count_zero) begin
            cmd_o.list_start = 1'b1;
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      CS_LIST: begin
        cmd_o.list_step = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_accept_in_list: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == CS_LIST) |-> !s_ready_o)
    else $error("input taken while listing");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.exec, cmd_o.list_start, cmd_o.list_step}))
    else $error("more than one datapath command");

  a_list_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.list_start |=> (state_q == CS_LIST))
    else $error("listing start without list state");

endmodule

// ===== rtl/plid_dp.sv =====
module plid_dp import plid_pkg::*; #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  plid_cmd_t                cmd_i,
  output plid_sts_t                sts_o,
  input  logic [OpcodeWidth-1:0]   opcode_i,
  input  logic [PositionWidth-1:0] position_i,
  input  logic [ValueWidth-1:0]    value_i,
  input  logic                     m_ready_i,
  output logic                     m_valid_o,
  output logic [StatusWidth-1:0]   status_o,
  output logic [ValueWidth-1:0]    value_res_o,
  output logic                     last_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned IW   = $clog2(CAPACITY);
  localparam int unsigned CMPW = (CW > PositionWidth) ? CW : PositionWidth;

  logic [ValueWidth-1:0] cells_q [CAPACITY];
  logic [ValueWidth-1:0] cells_d [CAPACITY];
  logic [ValueWidth-1:0] up_w    [CAPACITY];
  logic [ValueWidth-1:0] dn_w    [CAPACITY];
  logic [CW-1:0]         count_q, count_d;
  logic [IW-1:0]         idx_q, idx_d;
  logic                  out_valid_q, out_valid_d;
  status_e               status_q, status_d;
  logic [ValueWidth-1:0] value_q, value_d;
  logic                  last_q, last_d;

  logic [CMPW-1:0] pos_ext, count_ext;
  logic [IW-1:0]   ins_idx, del_idx, tail_idx;
  logic            count_zero, count_full, out_free;

  // neighbor taps for shifting
  for (genvar g = 0; g < CAPACITY; g++) begin : g_taps
    assign up_w[g] = cells_q[(g == 0) ? 0 : g - 1];
    assign dn_w[g] = cells_q[(g == CAPACITY - 1) ? g : g + 1];
  end

  assign pos_ext    = CMPW'(position_i);
  assign count_ext  = CMPW'(count_q);
  assign count_zero = (count_q == '0);
  assign count_full = (count_q == CW'(CAPACITY));
  assign ins_idx    = count_zero ? '0 : pos_ext[IW-1:0];
  assign del_idx    = IW'(pos_ext - CMPW'(1));
  assign tail_idx   = IW'(count_q - CW'(1));
  assign out_free   = !out_valid_q || m_ready_i;

  assign sts_o.out_free   = out_free;
  assign sts_o.count_zero = count_zero;
  assign sts_o.list_final = (idx_q == tail_idx);

  always_comb begin
    cells_d     = cells_q;
    count_d     = count_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q && !m_ready_i;
    status_d    = status_q;
    value_d     = value_q;
    last_d      = last_q;

    if (cmd_i.list_start) begin
      idx_d = '0;
    end

    if (cmd_i.list_step) begin
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      value_d     = cells_q[0];
      last_d      = (idx_q == tail_idx);
      idx_d       = idx_q + IW'(1);
      // rotate the occupied part toward the head
      for (int i = 0; i < CAPACITY; i++) begin
        cells_d[i] = (IW'(i) == tail_idx) ? cells_q[0] : dn_w[i];
      end
    end

    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      value_d     = '0;
      last_d      = 1'b1;
      case (opcode_i)
        OPC_INSERT: begin
          if (count_full) begin
            status_d = ST_FULL;
          end else if (!count_zero && (pos_ext > count_ext)) begin
            status_d = ST_BADPOS;
          end else begin
            for (int i = 0; i < CAPACITY; i++) begin
              if (IW'(i) > ins_idx) begin
                cells_d[i] = up_w[i];
              end else if (IW'(i) == ins_idx) begin
                cells_d[i] = value_i;
              end
            end
            count_d = count_q + CW'(1);
          end
        end
        OPC_DELETE: begin
          if (count_zero) begin
            status_d = ST_EMPTY;
          end else if ((pos_ext == '0) || (pos_ext > count_ext)) begin
            status_d = ST_BADPOS;
          end else begin
            value_d = cells_q[del_idx];
            for (int i = 0; i < CAPACITY; i++) begin
              if (IW'(i) >= del_idx) begin
                cells_d[i] = dn_w[i];
              end
            end
            count_d = count_q - CW'(1);
          end
        end
        OPC_LIST: begin
          // only reaches here on an empty list
          status_d = ST_EMPTY;
        end
        default: begin
          out_valid_d = out_valid_q && !m_ready_i;
          status_d    = status_q;
          value_d     = value_q;
          last_d      = last_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q  <= cells_d;
    status_q <= status_d;
    value_q  <= value_d;
    last_q   <= last_d;
  end

  assign m_valid_o   = out_valid_q;
  assign status_o    = status_q;
  assign value_res_o = value_q;
  assign last_o      = last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.exec |=> $stable(count_q))
    else $error("count moved without an operation");

  a_list_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.list_step |=> (m_valid_o && (value_res_o == $past(cells_q[0]))))
    else $error("listing step lost the head element");

endmodule
